/* rtl/pfa_pkg.sv */
// Shared types, codes and constants of the partition fit allocator.
package pfa_pkg;

    // Default number of partition slots in the table.
    localparam int NUM_PARTITIONS_DEF = 8;

    // Fixed field widths.
    localparam int MODE_W  = 2;
    localparam int ENTRY_W = 3;
    localparam int KB_W    = 16;
    localparam int ADDR_W  = 32;
    localparam int STAT_W  = 2;

    // One KB is 1024 bytes, a left shift by ten.
    localparam int KB_SHIFT = 10;

    // Command codes.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    // Placement rules held in the mode register.
    localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_LOADED  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_GRANTED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NO_FIT  = 2'd2;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic scan_step;
        logic commit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_dp_status;

endpackage

/* rtl/pfa_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module pfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/pfa_ctrl.sv */
// Sequencing state machine of the partition fit allocator.
module pfa_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_cmd,
    input  pfa_pkg::t_dp_status  i_status,
    output pfa_pkg::t_dp_cmd     o_cmd,
    output logic                 o_in_stall
);

    pfa_pkg::t_state r_state;
    pfa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfa_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            pfa_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = (i_cmd == pfa_pkg::CMD_ALLOC) ? pfa_pkg::ST_SCAN
                                                             : pfa_pkg::ST_DONE;
                end
            end
            pfa_pkg::ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = pfa_pkg::ST_DRAIN;
                end
            end
            pfa_pkg::ST_DRAIN: begin
                // The last slot's read data is compared in this cycle.
                n_state = pfa_pkg::ST_DONE;
            end
            pfa_pkg::ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = pfa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pfa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/pfa_dp.sv */
// Datapath of the partition fit allocator: table, scan compare, update and result register.
module pfa_dp #(
    parameter int NUM_PARTITIONS = pfa_pkg::NUM_PARTITIONS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pfa_pkg::t_dp_cmd              i_cmd_dp,
    output pfa_pkg::t_dp_status           o_status,
    input  logic                          i_cfg_we,
    input  logic [pfa_pkg::MODE_W-1:0]    i_cfg_wdata,
    input  logic                          i_cmd,
    input  logic [pfa_pkg::ENTRY_W-1:0]   i_entry_index,
    input  logic [pfa_pkg::KB_W-1:0]      i_entry_capacity_kb,
    input  logic [pfa_pkg::ADDR_W-1:0]    i_entry_start_addr,
    input  logic [pfa_pkg::KB_W-1:0]      i_request_kb,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [pfa_pkg::STAT_W-1:0]    o_status_code,
    output logic [pfa_pkg::ENTRY_W-1:0]   o_chosen_index,
    output logic [pfa_pkg::ADDR_W-1:0]    o_granted_start_addr,
    output logic [pfa_pkg::KB_W-1:0]      o_remaining_kb
);

    localparam int IDX_W = $clog2(NUM_PARTITIONS);
    localparam int ENT_W = pfa_pkg::KB_W + pfa_pkg::ADDR_W;

    // Mode register.
    logic [pfa_pkg::MODE_W-1:0] r_fit_mode;

    // Captured item.
    logic                         r_cmd;
    logic [pfa_pkg::ENTRY_W-1:0]  r_idx;
    logic [pfa_pkg::KB_W-1:0]     r_cap;
    logic [pfa_pkg::ADDR_W-1:0]   r_addr;
    logic [pfa_pkg::KB_W-1:0]     r_req;

    // Scan state.
    logic [IDX_W-1:0]             r_cnt;
    logic                         r_cmp_en;
    logic [IDX_W-1:0]             r_rd_idx;
    logic                         r_rd_valid;
    logic [NUM_PARTITIONS-1:0]    r_valid;

    // Best candidate so far.
    logic                         r_best_valid;
    logic [IDX_W-1:0]             r_best_idx;
    logic [pfa_pkg::KB_W-1:0]     r_best_cap;
    logic [pfa_pkg::ADDR_W-1:0]   r_best_start;

    // Result register.
    logic                         r_out_valid;
    logic [pfa_pkg::STAT_W-1:0]   r_out_status;
    logic [pfa_pkg::ENTRY_W-1:0]  r_out_index;
    logic [pfa_pkg::ADDR_W-1:0]   r_out_addr;
    logic [pfa_pkg::KB_W-1:0]     r_out_kb;

    logic [ENT_W-1:0]             rd_data;
    logic [pfa_pkg::KB_W-1:0]     rd_cap;
    logic [pfa_pkg::ADDR_W-1:0]   rd_start;
    logic                         fits;
    logic                         take;
    logic                         load_in_range;
    logic                         is_alloc;
    logic                         ram_we;
    logic [IDX_W-1:0]             ram_waddr;
    logic [ENT_W-1:0]             ram_wdata;
    logic [pfa_pkg::KB_W-1:0]     new_cap;
    logic [pfa_pkg::ADDR_W-1:0]   new_start;

    pfa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_PARTITIONS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd_dp.scan_step),
        .i_raddr (r_cnt),
        .o_rdata (rd_data)
    );

    // A slot never written since reset reads as empty.
    assign rd_cap   = r_rd_valid ? rd_data[ENT_W-1 -: pfa_pkg::KB_W] : '0;
    assign rd_start = rd_data[pfa_pkg::ADDR_W-1:0];

    assign fits = (rd_cap != '0) && (r_req != '0) && (rd_cap >= r_req);

    always_comb begin
        take = 1'b0;
        if (fits) begin
            if (!r_best_valid) begin
                take = 1'b1;
            end else if (r_fit_mode == pfa_pkg::FIT_BEST) begin
                take = rd_cap < r_best_cap;
            end else if (r_fit_mode == pfa_pkg::FIT_WORST) begin
                take = rd_cap > r_best_cap;
            end
        end
    end

    assign is_alloc      = (r_cmd == pfa_pkg::CMD_ALLOC);
    assign load_in_range = 32'(r_idx) < 32'(NUM_PARTITIONS);
    assign new_cap       = r_best_cap - r_req;
    assign new_start     = r_best_start + (32'(r_req) << pfa_pkg::KB_SHIFT);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_best_idx;
        ram_wdata = {new_cap, new_start};
        if (i_cmd_dp.commit) begin
            if (is_alloc) begin
                ram_we = r_best_valid;
            end else begin
                ram_we    = load_in_range;
                ram_waddr = IDX_W'(r_idx);
                ram_wdata = {r_cap, r_addr};
            end
        end
    end

    assign o_status.scan_last = (r_cnt == IDX_W'(NUM_PARTITIONS - 1));
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode   <= pfa_pkg::FIT_FIRST;
            r_valid      <= '0;
            r_cmp_en     <= 1'b0;
            r_best_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_cnt        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_fit_mode <= i_cfg_wdata;
            end
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
            r_cmp_en <= i_cmd_dp.scan_step;
            if (i_cmd_dp.capture) begin
                r_cnt        <= '0;
                r_best_valid <= 1'b0;
            end else begin
                if (i_cmd_dp.scan_step) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                if (r_cmp_en && take) begin
                    r_best_valid <= 1'b1;
                end
            end
            if (i_cmd_dp.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd_dp.capture) begin
            r_cmd  <= i_cmd;
            r_idx  <= i_entry_index;
            r_cap  <= i_entry_capacity_kb;
            r_addr <= i_entry_start_addr;
            r_req  <= i_request_kb;
        end
        if (i_cmd_dp.scan_step) begin
            r_rd_idx   <= r_cnt;
            r_rd_valid <= r_valid[r_cnt];
        end
        if (r_cmp_en && take) begin
            r_best_idx   <= r_rd_idx;
            r_best_cap   <= rd_cap;
            r_best_start <= rd_start;
        end
        if (i_cmd_dp.commit) begin
            if (!is_alloc) begin
                r_out_status <= pfa_pkg::STAT_LOADED;
                r_out_index  <= '0;
                r_out_addr   <= '0;
                r_out_kb     <= '0;
            end else if (r_best_valid) begin
                r_out_status <= pfa_pkg::STAT_GRANTED;
                r_out_index  <= pfa_pkg::ENTRY_W'(r_best_idx);
                r_out_addr   <= r_best_start;
                r_out_kb     <= new_cap;
            end else begin
                r_out_status <= pfa_pkg::STAT_NO_FIT;
                r_out_index  <= '0;
                r_out_addr   <= '0;
                r_out_kb     <= '0;
            end
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_status_code        = r_out_status;
    assign o_chosen_index       = r_out_index;
    assign o_granted_start_addr = r_out_addr;
    assign o_remaining_kb       = r_out_kb;

endmodule

/* rtl/partition_fit_allocator.sv */
// Top level of the partition fit allocator: controller and datapath.
//
// The block keeps a table of NUM_PARTITIONS free memory partitions, each with a
// capacity in KB and a start byte address, and handles one transfer at a time.
// A load transfer writes one slot. An allocate transfer scans the table one slot
// per cycle through the table memory's single read port and then writes the
// chosen slot back. The table reads as all empty after reset without any
// clearing pass, because each slot has a valid bit. The result waits in an
// output register, so a stalled result does not hold up the acceptance of the
// next transfer. The fit mode is written through i_cfg_we and i_cfg_wdata; the
// user must write it only while the block is idle, which the block itself does
// not enforce. Mode three behaves as first fit.
module partition_fit_allocator #(
    parameter int NUM_PARTITIONS = pfa_pkg::NUM_PARTITIONS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port for the fit mode register.
    input  logic                          i_cfg_we,
    input  logic [pfa_pkg::MODE_W-1:0]    i_cfg_wdata,
    // Input channel.
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_cmd,
    input  logic [pfa_pkg::ENTRY_W-1:0]   i_entry_index,
    input  logic [pfa_pkg::KB_W-1:0]      i_entry_capacity_kb,
    input  logic [pfa_pkg::ADDR_W-1:0]    i_entry_start_addr,
    input  logic [pfa_pkg::KB_W-1:0]      i_request_kb,
    // Result channel.
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [pfa_pkg::STAT_W-1:0]    o_status,
    output logic [pfa_pkg::ENTRY_W-1:0]   o_chosen_index,
    output logic [pfa_pkg::ADDR_W-1:0]    o_granted_start_addr,
    output logic [pfa_pkg::KB_W-1:0]      o_remaining_kb
);

    pfa_pkg::t_dp_cmd    dp_cmd;
    pfa_pkg::t_dp_status dp_status;

    // The controller sequences capture, scan and commit.
    pfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd),
        .o_in_stall (o_in_stall)
    );

    // The datapath holds the table, the best-candidate compare and the result.
    pfa_dp #(
        .NUM_PARTITIONS (NUM_PARTITIONS)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd_dp             (dp_cmd),
        .o_status             (dp_status),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_cmd                (i_cmd),
        .i_entry_index        (i_entry_index),
        .i_entry_capacity_kb  (i_entry_capacity_kb),
        .i_entry_start_addr   (i_entry_start_addr),
        .i_request_kb         (i_request_kb),
        .i_out_stall          (i_out_stall),
        .o_out_valid          (o_out_valid),
        .o_status_code        (o_status),
        .o_chosen_index       (o_chosen_index),
        .o_granted_start_addr (o_granted_start_addr),
        .o_remaining_kb       (o_remaining_kb)
    );

endmodule

/* tb/partition_fit_allocator_test.sv */
// Self-checking testbench for the partition fit allocator, with directed and random transfers.
`timescale 1ns / 100ps

module partition_fit_allocator_test;

    localparam int MODE_W   = pfa_pkg::MODE_W;
    localparam int ENTRY_W  = pfa_pkg::ENTRY_W;
    localparam int KB_W     = pfa_pkg::KB_W;
    localparam int ADDR_W   = pfa_pkg::ADDR_W;
    localparam int STAT_W   = pfa_pkg::STAT_W;
    localparam int KB_SHIFT = pfa_pkg::KB_SHIFT;

    localparam int NUM_SLOTS    = pfa_pkg::NUM_PARTITIONS_DEF;
    // Wait after the last owed result, long enough to cover any tail of a scan.
    localparam int SETTLE       = 2 * (NUM_SLOTS + 3);
    localparam int RANDOM_ITEMS = 1800;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 1000000;

    // One result transfer as the block presents it.
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [ENTRY_W-1:0] chosen;
        logic [ADDR_W-1:0]  start;
        logic [KB_W-1:0]    remain;
    } t_alloc_result;

    localparam t_alloc_result LOADED_RES = {pfa_pkg::STAT_LOADED, 3'd0, 32'd0, 16'd0};
    localparam t_alloc_result NO_FIT_RES = {pfa_pkg::STAT_NO_FIT, 3'd0, 32'd0, 16'd0};

    // A stimulus row either writes the fit mode or offers one input transfer.
    typedef enum logic {
        ROW_XFER,
        ROW_MODE
    } t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic [MODE_W-1:0]  mode;
        logic               cmd;
        logic [ENTRY_W-1:0] idx;
        logic [KB_W-1:0]    cap;
        logic [ADDR_W-1:0]  addr;
        logic [KB_W-1:0]    req;
        logic               typed;
        t_alloc_result      exp;
    } t_stim_row;

    // Ports of the block. Every input starts at a known value.
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [MODE_W-1:0]  i_cfg_wdata = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_cmd = pfa_pkg::CMD_LOAD;
    logic [ENTRY_W-1:0] i_entry_index = '0;
    logic [KB_W-1:0]    i_entry_capacity_kb = '0;
    logic [ADDR_W-1:0]  i_entry_start_addr = '0;
    logic [KB_W-1:0]    i_request_kb = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [STAT_W-1:0]  o_status;
    logic [ENTRY_W-1:0] o_chosen_index;
    logic [ADDR_W-1:0]  o_granted_start_addr;
    logic [KB_W-1:0]    o_remaining_kb;

    // The predictor's own copy of the partition table and the mode register.
    logic [KB_W-1:0]    part_cap   [NUM_SLOTS];
    logic [ADDR_W-1:0]  part_start [NUM_SLOTS];
    logic [MODE_W-1:0]  fit_mode_q = pfa_pkg::FIT_FIRST;

    // Results still owed by the block, oldest first.
    t_alloc_result      owed_results [$];

    // A directed row may carry a result typed in by hand; it travels with the payload.
    logic               drv_typed = 1'b0;
    t_alloc_result      drv_exp = LOADED_RES;

    t_stim_row          dir_tbl [$];

    // Idling control shared by the sender and the receiver.
    logic               quiet = 1'b0;
    logic               hold_req = 1'b0;
    logic               hold_done = 1'b0;
    int                 hold_cnt = 0;
    int                 stall_left = 0;

    int                 errors = 0;
    int                 items_taken = 0;
    int                 results_seen = 0;
    int                 grants = 0;
    int                 no_fits = 0;
    int                 mode_writes = 0;
    int                 cycle_cnt = 0;

    partition_fit_allocator #(
        .NUM_PARTITIONS(NUM_SLOTS)
    ) DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_cmd               (i_cmd),
        .i_entry_index       (i_entry_index),
        .i_entry_capacity_kb (i_entry_capacity_kb),
        .i_entry_start_addr  (i_entry_start_addr),
        .i_request_kb        (i_request_kb),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_status            (o_status),
        .o_chosen_index      (o_chosen_index),
        .o_granted_start_addr(o_granted_start_addr),
        .o_remaining_kb      (o_remaining_kb)
    );

    // A 2 ns clock.
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: a correct run ends far below this many cycles.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t ns: timeout after %0d cycles, %0d results still owed", $time,
                     cycle_cnt, owed_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Applies one accepted transfer to the predicted table and returns the result it owes.
    // A load writes its slot. An allocate picks the first, smallest or largest non-empty
    // slot that holds the request; ties keep the lowest index because a later slot only
    // replaces the pick when it is strictly better. Mode three falls back to first fit.
    function automatic t_alloc_result apply_command(input logic cmd,
                                                    input logic [ENTRY_W-1:0] idx,
                                                    input logic [KB_W-1:0] cap,
                                                    input logic [ADDR_W-1:0] addr,
                                                    input logic [KB_W-1:0] req);
        t_alloc_result r;
        int            pick;
        logic          better;
        r = LOADED_RES;
        pick = -1;
        if (cmd == pfa_pkg::CMD_LOAD) begin
            part_cap[idx] = cap;
            part_start[idx] = addr;
        end else begin
            // A zero request never fits anything.
            if (req != '0) begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (part_cap[i] != '0 && part_cap[i] >= req) begin
                        if (pick < 0) begin
                            pick = i;
                        end else begin
                            better = (fit_mode_q == pfa_pkg::FIT_BEST) ?
                                         (part_cap[i] < part_cap[pick]) :
                                     (fit_mode_q == pfa_pkg::FIT_WORST) ?
                                         (part_cap[i] > part_cap[pick]) :
                                     1'b0;
                            if (better) begin
                                pick = i;
                            end
                        end
                    end
                end
            end
            if (pick < 0) begin
                r = NO_FIT_RES;
            end else begin
                r.status = pfa_pkg::STAT_GRANTED;
                r.chosen = pick[ENTRY_W-1:0];
                r.start = part_start[pick];
                // The start address advances by the request in bytes and wraps at 2^32.
                part_start[pick] = part_start[pick] +
                                   ({{(ADDR_W-KB_W){1'b0}}, req} << KB_SHIFT);
                part_cap[pick] = part_cap[pick] - req;
                r.remain = part_cap[pick];
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Monitor. Results are checked before the input transfer of the same edge is
    // predicted; a result can never belong to a transfer accepted at that edge.
    always @(posedge i_clk) begin : monitor
        t_alloc_result got;
        t_alloc_result want;
        t_alloc_result pred;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                part_cap[i] = '0;
                part_start[i] = '0;
            end
            fit_mode_q = pfa_pkg::FIT_FIRST;
            owed_results.delete();
        end else begin
            if (i_cfg_we) begin
                fit_mode_q = i_cfg_wdata;
                mode_writes++;
            end
            if (o_out_valid && !i_out_stall) begin
                got = {o_status, o_chosen_index, o_granted_start_addr, o_remaining_kb};
                results_seen++;
                if (owed_results.size() == 0) begin
                    errors++;
                    $display("%0t ns: result with nothing expected, expected none, actual %h",
                             $time, got);
                end else begin
                    want = owed_results.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("chosen_index", want.chosen, got.chosen);
                    check_field("granted_start_addr", want.start, got.start);
                    check_field("remaining_kb", want.remain, got.remain);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                pred = apply_command(i_cmd, i_entry_index, i_entry_capacity_kb,
                                     i_entry_start_addr, i_request_kb);
                if (pred.status == pfa_pkg::STAT_GRANTED) begin
                    grants++;
                end
                if (pred.status == pfa_pkg::STAT_NO_FIT) begin
                    no_fits++;
                end
                items_taken++;
                owed_results.insert(owed_results.size(), drv_typed ? drv_exp : pred);
            end
        end
    end

    // Idle length for either side: mostly short, now and then a long stretch.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Receiver. One long hold-off, counted here, lets the block fill up and stall its
    // input while the sender keeps offering; otherwise stalls come in random bursts.
    always @(negedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_out_stall <= 1'b1;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_cnt <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 99) < 25) begin
                stall_left <= idle_len();
            end
        end
    end

    // Gap the sender leaves after a transfer. None in quiet phases or during the hold-off.
    function automatic int sender_gap();
        if (quiet || hold_cnt > 0 || $urandom_range(0, 1) == 0) begin
            return 0;
        end
        return idle_len();
    endfunction

    function automatic t_stim_row xfer_row(input logic cmd, input logic [ENTRY_W-1:0] idx,
                                           input logic [KB_W-1:0] cap,
                                           input logic [ADDR_W-1:0] addr,
                                           input logic [KB_W-1:0] req, input logic typed,
                                           input t_alloc_result exp);
        t_stim_row r;
        r.kind = ROW_XFER;
        r.mode = pfa_pkg::FIT_FIRST;
        r.cmd = cmd;
        r.idx = idx;
        r.cap = cap;
        r.addr = addr;
        r.req = req;
        r.typed = typed;
        r.exp = exp;
        return r;
    endfunction

    function automatic t_stim_row mode_row(input logic [MODE_W-1:0] m);
        t_stim_row r;
        r = xfer_row(pfa_pkg::CMD_LOAD, '0, '0, '0, '0, 1'b0, LOADED_RES);
        r.kind = ROW_MODE;
        r.mode = m;
        return r;
    endfunction

    function automatic t_alloc_result grant(input logic [ENTRY_W-1:0] idx,
                                            input logic [ADDR_W-1:0] addr,
                                            input logic [KB_W-1:0] rem);
        return {pfa_pkg::STAT_GRANTED, idx, addr, rem};
    endfunction

    // Appends one row to the directed table.
    task automatic add_row(input t_stim_row r);
        dir_tbl.insert(dir_tbl.size(), r);
    endtask

    // Offers one transfer from the falling edge and returns at the falling edge after it
    // is accepted, with valid still high so a back-to-back transfer needs no toggle.
    task automatic offer(input t_stim_row r);
        i_in_valid <= 1'b1;
        i_cmd <= r.cmd;
        i_entry_index <= r.idx;
        i_entry_capacity_kb <= r.cap;
        i_entry_start_addr <= r.addr;
        i_request_kb <= r.req;
        drv_typed <= r.typed;
        drv_exp <= r.exp;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic pause(input int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // The mode register is written only when the block is idle: every owed result has
    // arrived and the scan has had time to finish.
    task automatic set_mode_idle(input logic [MODE_W-1:0] m);
        i_in_valid <= 1'b0;
        while (owed_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Capacity for a random load: mostly small so that allocations exhaust slots,
    // sometimes empty, sometimes the full range.
    function automatic logic [KB_W-1:0] random_cap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return '0;
        end else if (r < 75) begin
            return KB_W'($urandom_range(1, 512));
        end else if (r < 92) begin
            return KB_W'($urandom_range(0, 65535));
        end
        return 16'hFFFF;
    endfunction

    // Start address for a random load, sometimes just below the top to force wrapping.
    function automatic logic [ADDR_W-1:0] random_addr();
        if ($urandom_range(0, 9) == 0) begin
            return 32'hFFFF_FFFF - $urandom_range(0, 65535);
        end
        return $urandom;
    endfunction

    // Request size: often an exact fit of a live slot, mostly small, at times zero or huge.
    function automatic logic [KB_W-1:0] random_req();
        int                r;
        int                s;
        logic [KB_W-1:0]   v;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            return '0;
        end else if (r < 25) begin
            s = $urandom_range(0, NUM_SLOTS - 1);
            v = part_cap[s];
            return (v == '0) ? KB_W'($urandom_range(1, 64)) : v;
        end else if (r < 70) begin
            return KB_W'($urandom_range(1, 64));
        end else if (r < 90) begin
            return KB_W'($urandom_range(1, 1024));
        end else if (r < 95) begin
            return 16'hFFFF;
        end
        return KB_W'($urandom_range(0, 65535));
    endfunction

    // Stimulus.
    initial begin : stimulus
        int              phase;
        int              len;
        int              base;
        int              random_sent;
        logic [MODE_W-1:0] m;
        t_stim_row       row;

        // Directed table. Rows with a typed result are ones whose answer is plain:
        // the empty table after reset, loads, exact fits, ties and extremes.
        // Empty table right after reset: nothing fits.
        add_row(xfer_row(pfa_pkg::CMD_ALLOC, 3'd0, 16'd0, 32'd0, 16'd1, 1'b1, NO_FIT_RES));
        // A zero request is refused.
        add_row(xfer_row(pfa_pkg::CMD_ALLOC, 3'd0, 16'd0, 32'd0, 16'd0, 1'b1, NO_FIT_RES));
        add_row(xfer_row(pfa_pkg::CMD_LOAD, 3'd0, 16'd100, 32'h1000_0000, 16'd0, 1'b1,
                         LOADED_RES));
        add_row(xfer_row(pfa_pkg::CMD_LOAD, 3'd1, 16'd50, 32'h2000_0000, 16'd0, 1'b1,
                         LOADED_RES));
        add_row(xfer_row(pfa_pkg::CMD_LOAD, 3'd2, 16'd200, 32'h3000_0000, 16'd0, 1'b1,
                         LOADED_RES));
        add_row(xfer_row(pfa_pkg::CMD_LOAD, 3'd3, 16'd50, 32'h4000_0000, 16'd0, 1'b1,
                         LOADED_RES));
        // A slot loaded with zero capacity stays empty and is never chosen.
        add_row(xfer_row(pfa_pkg::CMD_LOAD, 3'd4, 16'd0, 32'h5000_0000, 16'd0, 1'b1,
                         LOADED_RES));
        // The top slot sits just below 2^32 so that its start wraps.
        add_row(xfer_row(pfa_pkg::CMD_LOAD, 3'd7, 16'hFFFF, 32'hFFFF_FC00, 16'd0, 1'b1,
                         LOADED_RES));
        // First fit takes slot 0, then an exact fit empties it.
        add_row(xfer_row(pfa_pkg::CMD_ALLOC, 3'd0, 16'd0, 32'd0, 16'd60, 1'b1,
                         grant(3'd0, 32'h1000_0000, 16'd40)));
        add_row(xfer_row(pfa_pkg::CMD_ALLOC, 3'd0, 16'd0, 32'd0, 16'd40, 1'b1,
                         grant(3'd0, 32'h1000_F000, 16'd0)));
        add_row(xfer_row(pfa_pkg::CMD_ALLOC, 3'd0, 16'd0, 32'd0, 16'd300, 1'b0,
                         LOADED_RES));
        // Best fit: slots 1 and 3 tie at 50 KB, the lower index wins.
        add_row(mode_row(pfa_pkg::FIT_BEST));
        add_row(xfer_row(pfa_pkg::CMD_ALLOC, 3'd0, 16'd0, 32'd0, 16'd50, 1'b1,
                         grant(3'd1, 32'h2000_0000, 16'd0)));
        add_row(xfer_row(pfa_pkg::CMD_ALLOC, 3'd0, 16'd0, 32'd0, 16'd10, 1'b0,
                         LOADED_RES));
        // Worst fit, then a request larger than anything left.
        add_row(mode_row(pfa_pkg::FIT_WORST));
        add_row(xfer_row(pfa_pkg::CMD_ALLOC, 3'd0, 16'd0, 32'd0, 16'd1, 1'b0, LOADED_RES));
        add_row(xfer_row(pfa_pkg::CMD_ALLOC, 3'd0, 16'd0, 32'd0, 16'hFFFF, 1'b1,
                         NO_FIT_RES));
        // The unused mode value behaves as first fit.
        add_row(mode_row(2'd3));
        add_row(xfer_row(pfa_pkg::CMD_ALLOC, 3'd0, 16'd0, 32'd0, 16'd100, 1'b0,
                         LOADED_RES));
        add_row(xfer_row(pfa_pkg::CMD_LOAD, 3'd5, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
                         LOADED_RES));
        // Largest request, exactly fitting the largest slot at the top address.
        add_row(mode_row(pfa_pkg::FIT_FIRST));
        add_row(xfer_row(pfa_pkg::CMD_ALLOC, 3'd7, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
                         grant(3'd5, 32'hFFFF_FFFF, 16'd0)));
        add_row(xfer_row(pfa_pkg::CMD_LOAD, 3'd6, 16'd1, 32'd0, 16'd0, 1'b1, LOADED_RES));
        add_row(xfer_row(pfa_pkg::CMD_ALLOC, 3'd0, 16'd0, 32'd0, 16'd1, 1'b0, LOADED_RES));
        add_row(xfer_row(pfa_pkg::CMD_LOAD, 3'd0, 16'd0, 32'hFFFF_FFFF, 16'd0, 1'b1,
                         LOADED_RES));

        // Synchronous reset, released on a falling edge.
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tbl[k]) begin
            if (dir_tbl[k].kind == ROW_MODE) begin
                set_mode_idle(dir_tbl[k].mode);
            end else begin
                offer(dir_tbl[k]);
                pause(sender_gap());
            end
        end

        // Random phases. Each one picks a mode, fills the whole table with fresh
        // partitions and then mixes allocations with the odd reload, so slots are
        // carved up, emptied and refilled. All unused payload fields carry noise.
        phase = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            m = (phase < 4) ? MODE_W'(phase) : MODE_W'($urandom_range(0, 3));
            set_mode_idle(m);
            quiet = ($urandom_range(0, 3) == 0);
            if (phase == 1) begin
                hold_req <= 1'b1;
            end
            base = $urandom_range(0, NUM_SLOTS - 1);
            for (int k = 0; k < NUM_SLOTS; k++) begin
                row = xfer_row(pfa_pkg::CMD_LOAD, ENTRY_W'((base + k) % NUM_SLOTS),
                               random_cap(), random_addr(), KB_W'($urandom), 1'b0,
                               LOADED_RES);
                offer(row);
                pause(sender_gap());
                random_sent++;
            end
            len = $urandom_range(80, 200);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 3) == 0) begin
                    row = xfer_row(pfa_pkg::CMD_LOAD, ENTRY_W'($urandom), random_cap(),
                                   random_addr(), KB_W'($urandom), 1'b0, LOADED_RES);
                end else begin
                    row = xfer_row(pfa_pkg::CMD_ALLOC, ENTRY_W'($urandom), KB_W'($urandom),
                                   $urandom, random_req(), 1'b0, LOADED_RES);
                end
                offer(row);
                pause(sender_gap());
                random_sent++;
            end
            phase++;
        end

        // Drain: wait for every owed result, then a settling time for strays.
        i_in_valid <= 1'b0;
        while (owed_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE) @(negedge i_clk);

        $display("Run covered %0d transfers in and %0d results out over %0d random phases,",
                 items_taken, results_seen, phase);
        $display("with %0d grants, %0d refusals and %0d fit mode writes; %0d mismatches.",
                 grants, no_fits, mode_writes, errors);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
